@@ hw/rtl/ffa_pkg.sv @@
// Shared types, constants and helpers for the first-fit free-list allocator.
package ffa_pkg;

  // Table geometry
  localparam int ENTRIES = 16;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ADDR_W  = 16;
  // Bases can step past the address space after a take from a saturated region
  localparam int BASE_W  = ADDR_W + 1;
  localparam int SIZE_W  = ADDR_W + 1;
  // Three-way merge sum: size + length + size
  localparam int SUM_W   = SIZE_W + 2;

  // Whole address space, 2^ADDR_W units
  localparam logic [SIZE_W-1:0] SPACE = {1'b1, {ADDR_W{1'b0}}};

  // Request codes
  localparam logic OP_RELEASE = 1'b0;
  localparam logic OP_ALLOC   = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  // Table update broadcast to every cell
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_MERGE_BOTH,
    ACT_MERGE_LO,
    ACT_MERGE_HI,
    ACT_INSERT,
    ACT_TAKE,
    ACT_TAKE_DROP
  } act_t;

  // Command bus from the controller to the cell row
  typedef struct packed {
    logic              eval;
    logic              decide;
    logic              apply;
    act_t              act;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
  } cell_cmd_t;

  // Per-cell report back to the controller
  typedef struct packed {
    logic              lo_hit;
    logic              hi_hit;
    logic              fit_hit;
    logic              fit_exact;
    logic [ADDR_W-1:0] fit_base;
  } cell_rpt_t;

  // Saturate a merged size at the size of the address space
  function automatic logic [SIZE_W-1:0] cap_size(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] lim;
    lim = SUM_W'(SPACE);
    return (v > lim) ? SPACE : v[SIZE_W-1:0];
  endfunction

endpackage

@@ hw/rtl/ffa_cell.sv @@
// One free-table entry: local compares, chain links and shift-in update.
module ffa_cell import ffa_pkg::*; (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic              used,
  input  logic [BASE_W-1:0] left_base,
  input  logic [SIZE_W-1:0] left_size,
  input  logic [BASE_W-1:0] right_base,
  input  logic [SIZE_W-1:0] right_size,
  input  logic              pref_in,
  input  logic              nxt_pref,
  input  logic              seen_in,
  output logic              pref_out,
  output logic              seen_out,
  output logic [BASE_W-1:0] base_q,
  output logic [SIZE_W-1:0] size_q,
  output cell_rpt_t         rpt
);

  logic [BASE_W-1:0] base_r, base_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;

  // Compare flags from the evaluate pass
  logic le_r, end_r, hi_r, fit_r;
  // Position roles from the decide pass
  logic is_lo_r, at_pos_r, ge_pos_r, gt_pos_r, is_fit_r, ge_fit_r;

  logic [SIZE_W:0]   end_sum;
  logic [BASE_W-1:0] rel_end;
  logic              at_pos, is_fit;

  assign base_q = base_r;
  assign size_q = size_r;

  // Local compares against the broadcast request
  assign end_sum = {1'b0, base_r} + {1'b0, size_r};
  assign rel_end = {1'b0, cmd.start} + {1'b0, cmd.len};

  // Chain links: all entries so far at or below start; a fit seen so far
  assign pref_out = pref_in & le_r;
  assign seen_out = seen_in | fit_r;
  assign at_pos   = pref_in & ~le_r;
  assign is_fit   = fit_r & ~seen_in;

  // Report to the controller
  always_comb begin
    rpt.lo_hit    = pref_out & ~nxt_pref & end_r;
    rpt.hi_hit    = at_pos & hi_r;
    rpt.fit_hit   = is_fit;
    rpt.fit_exact = is_fit & (size_r == {1'b0, cmd.len});
    rpt.fit_base  = is_fit ? base_r[ADDR_W-1:0] : '0;
  end

  // Entry update for the broadcast action
  always_comb begin
    base_nxt = base_r;
    size_nxt = size_r;
    case (cmd.act)
      ACT_MERGE_BOTH: begin
        if (is_lo_r) begin
          size_nxt = cap_size(SUM_W'(size_r) + SUM_W'(cmd.len) + SUM_W'(right_size));
        end else if (ge_pos_r) begin
          base_nxt = right_base;
          size_nxt = right_size;
        end
      end
      ACT_MERGE_LO: begin
        if (is_lo_r) begin
          size_nxt = cap_size(SUM_W'(size_r) + SUM_W'(cmd.len));
        end
      end
      ACT_MERGE_HI: begin
        if (at_pos_r) begin
          base_nxt = {1'b0, cmd.start};
          size_nxt = cap_size(SUM_W'(size_r) + SUM_W'(cmd.len));
        end
      end
      ACT_INSERT: begin
        if (at_pos_r) begin
          base_nxt = {1'b0, cmd.start};
          size_nxt = {1'b0, cmd.len};
        end else if (gt_pos_r) begin
          base_nxt = left_base;
          size_nxt = left_size;
        end
      end
      ACT_TAKE: begin
        if (is_fit_r) begin
          base_nxt = base_r + {1'b0, cmd.len};
          size_nxt = size_r - {1'b0, cmd.len};
        end
      end
      ACT_TAKE_DROP: begin
        if (ge_fit_r) begin
          base_nxt = right_base;
          size_nxt = right_size;
        end
      end
      default: begin
        base_nxt = base_r;
        size_nxt = size_r;
      end
    endcase
  end

  // Flags, roles and entry storage
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      le_r  <= used & (base_r <= {1'b0, cmd.start});
      end_r <= used & (end_sum == {2'b00, cmd.start});
      hi_r  <= used & (rel_end == base_r);
      fit_r <= used & ({1'b0, cmd.len} <= size_r);
    end
    if (cmd.decide) begin
      is_lo_r  <= pref_out & ~nxt_pref;
      at_pos_r <= at_pos;
      ge_pos_r <= ~pref_out;
      gt_pos_r <= ~pref_in;
      is_fit_r <= is_fit;
      ge_fit_r <= seen_out;
    end
    if (cmd.apply) begin
      base_r <= base_nxt;
      size_r <= size_nxt;
    end
  end

endmodule

@@ hw/rtl/first_fit_free_list_allocator_unit.sv @@
// First-fit free-list allocator: controller and the row of table cells.
//
// Input channel (in_*): opcode 0 releases region_start/region_length back to
// the free table, opcode 1 allocates region_length units first-fit. An item
// is taken when in_valid is high and in_stall is low.
// Result channel (out_*): one item per request with status, the granted
// start address (zero unless an allocate succeeds) and the number of free
// table entries after the request.
// Each request walks three passes over the cell row: evaluate (every cell
// compares itself with the request), decide (position and first-fit chains
// ripple through the row, the controller picks the update) and apply (each
// cell loads its new entry, from itself or from a neighbor). The result is
// registered when the apply pass completes; a new request is taken only
// after that, once the controller is back in idle.
// in_stall is high while a request is in the passes. A stalled result stays
// in the output register; a following request runs up to its apply pass and
// waits there until the register frees.
// Reset empties the table at once (entry count to zero) and clears out_valid.
module first_fit_free_list_allocator_unit import ffa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [ADDR_W-1:0] in_region_start,
  input  logic [ADDR_W-1:0] in_region_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_alloc_start,
  output logic [CNT_W-1:0]  out_free_count
);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DECIDE, S_APPLY} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic              op_r;
  logic [ADDR_W-1:0] start_r, len_r;
  act_t              act_r, act_nxt;
  status_t           st_r, st_nxt;
  logic [ADDR_W-1:0] grant_r, grant_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_start_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              apply_go;
  cell_cmd_t         cmd;
  logic [ENTRIES-1:0] used;
  logic [ENTRIES:0]  pref_c, seen_c;
  logic [BASE_W-1:0] base_q [ENTRIES];
  logic [SIZE_W-1:0] size_q [ENTRIES];
  cell_rpt_t         rpt [ENTRIES];

  logic              join_lo, join_hi, found, exact;
  logic [ADDR_W-1:0] fit_base;
  logic [ADDR_W:0]   rel_end;
  logic              bad;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_alloc_start = out_start_r;
  assign out_free_count  = out_count_r;

  // Apply waits for a free output register
  assign apply_go = (state_r == S_APPLY) && (!out_valid_r || !out_stall);

  // Broadcast command
  always_comb begin
    cmd.eval   = (state_r == S_EVAL);
    cmd.decide = (state_r == S_DECIDE);
    cmd.apply  = apply_go;
    cmd.act    = act_r;
    cmd.start  = start_r;
    cmd.len    = len_r;
  end

  // Cell row with neighbor links
  assign pref_c[0] = 1'b1;
  assign seen_c[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [BASE_W-1:0] lb, rb;
    logic [SIZE_W-1:0] ls, rs;
    logic              np;

    assign used[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign lb = '0;
      assign ls = '0;
    end else begin : g_mid_l
      assign lb = base_q[i-1];
      assign ls = size_q[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign rb = '0;
      assign rs = '0;
      assign np = 1'b0;
    end else begin : g_mid_r
      assign rb = base_q[i+1];
      assign rs = size_q[i+1];
      assign np = pref_c[i+2];
    end

    ffa_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .used       (used[i]),
      .left_base  (lb),
      .left_size  (ls),
      .right_base (rb),
      .right_size (rs),
      .pref_in    (pref_c[i]),
      .nxt_pref   (np),
      .seen_in    (seen_c[i]),
      .pref_out   (pref_c[i+1]),
      .seen_out   (seen_c[i+1]),
      .base_q     (base_q[i]),
      .size_q     (size_q[i]),
      .rpt        (rpt[i])
    );
  end

  // Gather cell reports
  always_comb begin
    join_lo  = 1'b0;
    join_hi  = 1'b0;
    found    = 1'b0;
    exact    = 1'b0;
    fit_base = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      join_lo  = join_lo | rpt[k].lo_hit;
      join_hi  = join_hi | rpt[k].hi_hit;
      found    = found | rpt[k].fit_hit;
      exact    = exact | rpt[k].fit_exact;
      fit_base = fit_base | rpt[k].fit_base;
    end
  end

  // Request checks and the update decision
  assign rel_end = {1'b0, start_r} + {1'b0, len_r};
  assign bad = (len_r == '0) || ((op_r == OP_RELEASE) && (rel_end > SPACE));

  always_comb begin
    act_nxt   = ACT_NONE;
    st_nxt    = ST_OK;
    grant_nxt = '0;
    cnt_nxt   = count_r;
    if (bad) begin
      st_nxt = ST_BAD;
    end else if (op_r == OP_ALLOC) begin
      if (found) begin
        grant_nxt = fit_base;
        if (exact) begin
          act_nxt = ACT_TAKE_DROP;
          cnt_nxt = count_r - CNT_W'(1);
        end else begin
          act_nxt = ACT_TAKE;
        end
      end else begin
        st_nxt = ST_NOFIT;
      end
    end else if (join_lo && join_hi) begin
      act_nxt = ACT_MERGE_BOTH;
      cnt_nxt = count_r - CNT_W'(1);
    end else if (join_lo) begin
      act_nxt = ACT_MERGE_LO;
    end else if (join_hi) begin
      act_nxt = ACT_MERGE_HI;
    end else if (count_r == CNT_W'(ENTRIES)) begin
      st_nxt = ST_FULL;
    end else begin
      act_nxt = ACT_INSERT;
      cnt_nxt = count_r + CNT_W'(1);
    end
  end

  // Sequencer, entry count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      act_r       <= ACT_NONE;
    end else begin
      // Output valid: set by apply, cleared once the item is taken
      if (apply_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          act_r <= ACT_NONE;
          if (in_valid) begin
            op_r    <= in_opcode;
            start_r <= in_region_start;
            len_r   <= in_region_length;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          act_r   <= act_nxt;
          st_r    <= st_nxt;
          grant_r <= grant_nxt;
          cnt_r   <= cnt_nxt;
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (apply_go) begin
            count_r      <= cnt_r;
            out_status_r <= st_r;
            out_start_r  <= grant_r;
            out_count_r  <= cnt_r;
            act_r        <= ACT_NONE;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Entry count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("free entry count beyond table size");

  // A waiting result reports the current entry count
  a_count_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r == count_r))
    else $error("reported free count differs from table");

  // Only a successful allocate grants an address
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_start_r == '0))
    else $error("address granted on a failed request");

  // Entry count moves only in the apply pass
  a_count_apply: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> $past(state_r == S_APPLY))
    else $error("entry count changed outside apply pass");

  // A failed request leaves the table untouched
  a_fail_noact: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_APPLY) && (st_r != ST_OK)) |-> (act_r == ACT_NONE))
    else $error("table update on a failed request");

endmodule

@@ tb/sv/first_fit_free_list_allocator_unit_tb.sv @@
// Self-checking testbench for the first-fit free-list allocator unit.
`timescale 1ns / 100ps

module first_fit_free_list_allocator_unit_tb;
  import ffa_pkg::*;

  localparam int unsigned UNITS = 1 << ADDR_W;
  // Long receiver hold-off used to back the block up
  localparam int HOLD_CYCLES = 300;
  // Cycles with no item moving on either side before the run is abandoned
  localparam int QUIET_LIMIT = 2000;

  // One expected result item
  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] start;
    logic [CNT_W-1:0]  count;
  } grant_t;

  // A region currently held by the traffic generator
  typedef struct {
    int unsigned base;
    int unsigned len;
  } span_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_opcode = OP_RELEASE;
  logic [ADDR_W-1:0] in_region_start = '0;
  logic [ADDR_W-1:0] in_region_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [ADDR_W-1:0] out_alloc_start;
  logic [CNT_W-1:0]  out_free_count;

  // Shadow copy of the free list, ascending base order
  int unsigned fl_base [ENTRIES];
  int unsigned fl_size [ENTRIES];
  int unsigned fl_count = 0;

  grant_t pending_grants[$];
  span_t  held_spans[$];
  int     errors = 0;
  int     snd_idle_pct = 0;
  int     rcv_stall_pct = 0;
  logic   hold_start = 1'b0;
  int     hold_left = 0;
  int     quiet_cycles = 0;

  first_fit_free_list_allocator_unit i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Merged sizes never exceed the whole address space
  function automatic int unsigned cap_units(input int unsigned v);
    return (v > UNITS) ? UNITS : v;
  endfunction

  task automatic drop_slot(input int unsigned idx);
    for (int unsigned k = idx; k + 1 < fl_count; k++) begin
      fl_base[k] = fl_base[k+1];
      fl_size[k] = fl_size[k+1];
    end
    fl_count--;
  endtask

  // Apply one request to the shadow list and work out its result
  task automatic predict_grant(input logic op, input logic [ADDR_W-1:0] start,
                               input logic [ADDR_W-1:0] len, output grant_t g);
    int unsigned pos;
    int unsigned s;
    int unsigned l;
    bit          join_lo;
    bit          join_hi;
    s = start;
    l = len;
    pos = 0;
    join_lo = 1'b0;
    join_hi = 1'b0;
    g.status = ST_OK;
    g.start = '0;
    if (op == OP_RELEASE) begin
      if (l == 0 || s + l > UNITS) begin
        g.status = ST_BAD;
      end else begin
        // equal bases sort after the existing entry
        while (pos < fl_count && fl_base[pos] <= s) pos++;
        if (pos > 0) join_lo = (fl_base[pos-1] + fl_size[pos-1] == s);
        if (pos < fl_count) join_hi = (s + l == fl_base[pos]);
        if (join_lo && join_hi) begin
          fl_size[pos-1] = cap_units(fl_size[pos-1] + l + fl_size[pos]);
          drop_slot(pos);
        end else if (join_lo) begin
          fl_size[pos-1] = cap_units(fl_size[pos-1] + l);
        end else if (join_hi) begin
          fl_base[pos] = s;
          fl_size[pos] = cap_units(fl_size[pos] + l);
        end else if (fl_count >= ENTRIES) begin
          g.status = ST_FULL;
        end else begin
          for (int unsigned k = fl_count; k > pos; k--) begin
            fl_base[k] = fl_base[k-1];
            fl_size[k] = fl_size[k-1];
          end
          fl_base[pos] = s;
          fl_size[pos] = l;
          fl_count++;
        end
      end
    end else if (l == 0) begin
      // a 16-bit length can never exceed the address space
      g.status = ST_BAD;
    end else begin
      g.status = ST_NOFIT;
      for (int unsigned i = 0; i < fl_count; i++) begin
        if (l <= fl_size[i]) begin
          g.status = ST_OK;
          g.start = ADDR_W'(fl_base[i]);
          fl_base[i] += l;
          fl_size[i] -= l;
          if (fl_size[i] == 0) drop_slot(i);
          break;
        end
      end
    end
    g.count = CNT_W'(fl_count);
  endtask

  // Offer one item, wait for it to be taken, then log its expected result
  task automatic send_item(input logic op, input logic [ADDR_W-1:0] start,
                           input logic [ADDR_W-1:0] len, output grant_t g);
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_region_start <= start;
    in_region_length <= len;
    do @(posedge clk); while (in_stall);
    predict_grant(op, start, len, g);
    pending_grants.insert(pending_grants.size(), g);
  endtask

  // Sender goes quiet until every expected result is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Mostly short lengths, now and then large ones
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(32, 1);
    if (r < 90) return $urandom_range(1024, 1);
    if (r < 97) return $urandom_range(16384, 1);
    return $urandom_range(65535, 1);
  endfunction

  // One random item: allocate, hand back a held region, release fresh space, or noise
  task automatic traffic_item();
    grant_t      g;
    span_t       sp;
    int unsigned sel;
    int unsigned idx;
    int unsigned s;
    int unsigned l;
    int unsigned part;
    sel = $urandom_range(99);
    if (sel < 38) begin
      l = pick_len();
      send_item(OP_ALLOC, ADDR_W'($urandom), ADDR_W'(l), g);
      if (g.status == ST_OK) held_spans.insert(held_spans.size(), '{g.start, l});
    end else if (sel < 70 && held_spans.size() != 0) begin
      idx = $urandom_range(held_spans.size() - 1);
      sp = held_spans[idx];
      if (sp.len > 1 && $urandom_range(3) == 0) begin
        // give back the front part, keep the rest
        part = $urandom_range(sp.len - 1, 1);
        held_spans[idx] = '{sp.base + part, sp.len - part};
        sp.len = part;
      end else begin
        held_spans.delete(idx);
      end
      send_item(OP_RELEASE, ADDR_W'(sp.base), ADDR_W'(sp.len), g);
      if (g.status == ST_FULL) held_spans.insert(held_spans.size(), sp);
    end else if (sel < 85) begin
      s = $urandom_range(UNITS - 1);
      l = pick_len();
      if (s + l > UNITS) l = UNITS - s;
      send_item(OP_RELEASE, ADDR_W'(s), ADDR_W'(l), g);
    end else begin
      case ($urandom_range(3))
        0: send_item(1'($urandom_range(1)), ADDR_W'($urandom), '0, g);
        1: begin
          // runs past the top of the address space
          s = $urandom_range(65535, 2);
          l = $urandom_range(65535, UNITS - s + 1);
          send_item(OP_RELEASE, ADDR_W'(s), ADDR_W'(l), g);
        end
        2: send_item(1'($urandom), ADDR_W'($urandom), ADDR_W'($urandom), g);
        default: begin
          // overlaps a listed free region, same base
          s = (fl_count != 0) ? fl_base[$urandom_range(fl_count - 1)] : $urandom_range(65535);
          l = $urandom_range(64, 1);
          if (s + l > UNITS) l = UNITS - s;
          send_item(OP_RELEASE, ADDR_W'(s), ADDR_W'(l), g);
        end
      endcase
    end
  endtask

  // Zero lengths, the top edge of the space, whole-space region, empty list
  task automatic test_bad_lengths();
    grant_t g;
    send_item(OP_ALLOC, 16'h1234, 16'd5, g);
    send_item(OP_RELEASE, 16'd40, 16'd0, g);
    send_item(OP_ALLOC, 16'hffff, 16'd0, g);
    send_item(OP_RELEASE, 16'hffff, 16'd2, g);
    send_item(OP_RELEASE, 16'hffff, 16'd1, g);
    send_item(OP_RELEASE, 16'd0, 16'hffff, g);
    send_item(OP_ALLOC, 16'd0, 16'hffff, g);
    send_item(OP_ALLOC, 16'hffff, 16'd1, g);
  endtask

  // Insert, join both sides, join below, join above, equal base, first fit
  task automatic test_merges();
    grant_t g;
    send_item(OP_RELEASE, 16'd100, 16'd50, g);
    send_item(OP_RELEASE, 16'd200, 16'd50, g);
    send_item(OP_RELEASE, 16'd150, 16'd50, g);
    send_item(OP_RELEASE, 16'd250, 16'd10, g);
    send_item(OP_RELEASE, 16'd90, 16'd10, g);
    send_item(OP_RELEASE, 16'd90, 16'd5, g);
    send_item(OP_ALLOC, 16'd0, 16'd200, g);
  endtask

  // Fill every entry, overflow once, then join a neighbor while full
  task automatic test_table_full();
    grant_t      g;
    int unsigned base;
    base = 1000;
    do begin
      send_item(OP_RELEASE, ADDR_W'(base), 16'd16, g);
      base += 64;
    end while (g.status != ST_FULL);
    send_item(OP_RELEASE, 16'd1016, 16'd8, g);
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n);
    wait_drain();
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    repeat (n) traffic_item();
    wait_drain();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_output_backpressure();
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (12) traffic_item();
    wait_drain();
  endtask

  // Hold-off counter
  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Result checking and receiver stalls
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result: status %0d start %0d count %0d",
                 $time, out_status, out_alloc_start, out_free_count);
        errors++;
      end else begin
        g = pending_grants.pop_front();
        if (out_status !== g.status) begin
          $display("%0t: status expected %0d, got %0d", $time, g.status, out_status);
          errors++;
        end
        if (out_alloc_start !== g.start) begin
          $display("%0t: alloc_start expected %0d, got %0d", $time, g.start, out_alloc_start);
          errors++;
        end
        if (out_free_count !== g.count) begin
          $display("%0t: free_count expected %0d, got %0d", $time, g.count, out_free_count);
          errors++;
        end
      end
    end
    out_stall <= (hold_left != 0) ||
                 (rcv_stall_pct > 0 && $urandom_range(99) < rcv_stall_pct);
  end

  // Watchdog on cycles where no item moves
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("first_fit_free_list_allocator_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bad_lengths();
    test_merges();
    test_table_full();
    test_random_traffic(0, 0, 160);
    test_random_traffic(52, 0, 160);
    test_random_traffic(0, 52, 160);
    test_random_traffic(6, 6, 160);
    test_output_backpressure();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("first_fit_free_list_allocator_unit verification clean");
    end else begin
      $display("first_fit_free_list_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
